/* design/fpa_pkg.sv */
// Shared types, opcodes and helper functions for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_EQ      = 4'd4,
    OP_NE      = 4'd5,
    OP_LT      = 4'd6,
    OP_LE      = 4'd7,
    OP_GT      = 4'd8,
    OP_GE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_DIVZERO = 2'd2
  } status_t;

  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;

  typedef struct packed {
    op_t                kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_flag;
    status_t            status;
  } rsp_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    op_t                kind;
    rsp_t               early;
    logic signed [63:0] prod;
    logic               dneg;
    logic               dzero;
  } side_t;

  // Saturate a 33-bit signed sum to 32 bits
  function automatic rsp_t clamp33(input logic signed [32:0] v);
    rsp_t r;
    r.compare_flag = 1'b0;
    r.status       = ST_OK;
    r.result_value = v[31:0];
    if (v > 33'sh0_7FFF_FFFF) begin
      r.result_value = SMAX;
      r.status       = ST_SAT;
    end else if (v < 33'sh1_8000_0000) begin
      r.result_value = SMIN;
      r.status       = ST_SAT;
    end
    return r;
  endfunction

  // Saturate a 64-bit signed value to 32 bits
  function automatic rsp_t clamp64(input logic signed [63:0] v);
    rsp_t r;
    r.compare_flag = 1'b0;
    r.status       = ST_OK;
    r.result_value = v[31:0];
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.result_value = SMAX;
      r.status       = ST_SAT;
    end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
      r.result_value = SMIN;
      r.status       = ST_SAT;
    end
    return r;
  endfunction

endpackage

/* design/fpa_front.sv */
// First stage: simple operations, the multiplier and divider operand setup.
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  fpa_pkg::req_t             in_item,
  output logic                      out_valid,
  output fpa_pkg::side_t            out_side,
  output logic [32+FRAC_BITS-1:0]   out_num,
  output logic [31:0]               out_den
);
  import fpa_pkg::*;

  logic signed [31:0] a, b;
  logic signed [32:0] ax, bx;
  logic signed [63:0] wide;
  logic        [32:0] amag, tmag;
  logic        [31:0] a_abs, b_abs;
  rsp_t               early;
  side_t              side_next;

  assign a  = in_item.operand_a;
  assign b  = in_item.operand_b;
  assign ax = {a[31], a};
  assign bx = {b[31], b};

  // Compute the simple operations combinationally
  always_comb begin
    early.result_value = '0;
    early.compare_flag = 1'b0;
    early.status       = ST_OK;
    wide = 64'(a) <<< FRAC_BITS;
    amag = a[31] ? 33'(33'd0 - ax) : 33'(ax);
    tmag = amag >> FRAC_BITS;
    case (in_item.kind)
      OP_ADD:     early = clamp33(ax + bx);
      OP_SUB:     early = clamp33(ax - bx);
      OP_EQ:      early.compare_flag = (a == b);
      OP_NE:      early.compare_flag = (a != b);
      OP_LT:      early.compare_flag = (a < b);
      OP_LE:      early.compare_flag = (a <= b);
      OP_GT:      early.compare_flag = (a > b);
      OP_GE:      early.compare_flag = (a >= b);
      OP_MIN:     early.result_value = (a <= b) ? a : b;
      OP_MAX:     early.result_value = (a >= b) ? a : b;
      OP_INC:     early = clamp33(ax + 33'sd1);
      OP_DEC:     early = clamp33(ax - 33'sd1);
      OP_TOINT:   early.result_value = a[31] ? 32'(33'd0 - tmag) : tmag[31:0];
      OP_FROMINT: early = clamp64(wide);
      default:    early.result_value = '0;
    endcase
  end

  // Divider operand magnitudes
  assign a_abs = a[31] ? 32'(32'd0 - a) : a;
  assign b_abs = b[31] ? 32'(32'd0 - b) : b;

  always_comb begin
    side_next.kind  = in_item.kind;
    side_next.early = early;
    side_next.prod  = 64'(a) * 64'(b);
    side_next.dneg  = a[31] ^ b[31];
    side_next.dzero = (b == 32'sd0);
  end

  // Register the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_side <= side_next;
      out_num  <= {a_abs, {FRAC_BITS{1'b0}}};
      out_den  <= b_abs;
    end
  end

endmodule

/* design/fpa_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module fpa_div #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  fpa_pkg::side_t            in_side,
  input  logic [32+FRAC_BITS-1:0]   in_num,
  input  logic [31:0]               in_den,
  output logic                      out_valid,
  output fpa_pkg::side_t            out_side,
  output logic [32+FRAC_BITS-1:0]   out_quo,
  output logic [31:0]               out_rem,
  output logic [31:0]               out_den
);
  import fpa_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  logic            vq    [QW];
  side_t           sideq [QW];
  logic [QW-1:0]   numq  [QW];
  logic [QW-1:0]   quoq  [QW];
  logic [31:0]     remq  [QW];
  logic [31:0]     denq  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          v_in;
    side_t         s_in;
    logic [QW-1:0] n_in, q_in;
    logic [31:0]   r_in, d_in;
    logic [32:0]   t;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = in_side;
      assign n_in = in_num;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = in_den;
    end else begin : g_next
      assign v_in = vq[i-1];
      assign s_in = sideq[i-1];
      assign n_in = numq[i-1];
      assign q_in = quoq[i-1];
      assign r_in = remq[i-1];
      assign d_in = denq[i-1];
    end

    // Trial subtract of the shifted partial remainder
    assign t  = {r_in, n_in[QW-1]};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[i] <= 1'b0;
      end else if (adv) begin
        vq[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sideq[i] <= s_in;
        numq[i]  <= {n_in[QW-2:0], 1'b0};
        quoq[i]  <= {q_in[QW-2:0], ge};
        remq[i]  <= ge ? 32'(t - {1'b0, d_in}) : t[31:0];
        denq[i]  <= d_in;
      end
    end
  end

  assign out_valid = vq[QW-1];
  assign out_side  = sideq[QW-1];
  assign out_quo   = quoq[QW-1];
  assign out_rem   = remq[QW-1];
  assign out_den   = denq[QW-1];

endmodule

/* design/fpa_back.sv */
// Last two stages: rounding of multiply and divide, then saturation and result select.
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  fpa_pkg::side_t            in_side,
  input  logic [32+FRAC_BITS-1:0]   in_quo,
  input  logic [31:0]               in_rem,
  input  logic [31:0]               in_den,
  output logic                      out_valid,
  output fpa_pkg::rsp_t             out_item
);
  import fpa_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  logic [63:0] pmag, pround, mag_next;
  logic [QW:0] qround;
  logic        neg_next, up;

  // Round multiply and divide magnitudes half away from zero
  always_comb begin
    pmag   = in_side.prod[63] ? 64'(64'd0 - in_side.prod) : 64'(in_side.prod);
    pround = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    up     = ({in_rem, 1'b0} >= {1'b0, in_den});
    qround = {1'b0, in_quo} + {{QW{1'b0}}, up};
    if (in_side.kind == OP_MUL) begin
      mag_next = pround;
      neg_next = in_side.prod[63];
    end else begin
      mag_next = {{(63-QW){1'b0}}, qround};
      neg_next = in_side.dneg;
    end
  end

  logic        v1;
  side_t       side1;
  logic [63:0] mag1;
  logic        neg1;
  rsp_t        rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1 <= in_side;
      mag1  <= mag_next;
      neg1  <= neg_next;
    end
  end

  // Saturate the rounded magnitude and pick the item's result
  always_comb begin
    rsp_next = side1.early;
    if ((side1.kind == OP_DIV) && side1.dzero) begin
      rsp_next.result_value = '0;
      rsp_next.compare_flag = 1'b0;
      rsp_next.status       = ST_DIVZERO;
    end else if ((side1.kind == OP_MUL) || (side1.kind == OP_DIV)) begin
      rsp_next.compare_flag = 1'b0;
      rsp_next.status       = ST_OK;
      if (neg1) begin
        if (mag1 > 64'h0000_0000_8000_0000) begin
          rsp_next.result_value = SMIN;
          rsp_next.status       = ST_SAT;
        end else begin
          rsp_next.result_value = 32'(64'd0 - mag1);
        end
      end else begin
        if (mag1 > 64'h0000_0000_7FFF_FFFF) begin
          rsp_next.result_value = SMAX;
          rsp_next.status       = ST_SAT;
        end else begin
          rsp_next.result_value = mag1[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= rsp_next;
    end
  end

endmodule

/* design/fixed_point_alu.sv */
// Top level of the pipelined signed 32-bit fixed-point ALU.
// Signed Q(32-FRAC_BITS).FRAC_BITS ALU: one item per cycle enters while
// req_stall is low, and every opcode alike passes through all the stages.
// The divider resolves one quotient bit per pipeline stage over
// 32+FRAC_BITS stages, with one setup stage in front and a rounding and
// a saturation stage behind. The whole pipe advances together; it holds
// while an output item waits under rsp_stall, and req_stall is high
// exactly then. Multiply and divide round half away from zero, range
// overflow saturates with status 1, and a zero divisor returns zero with
// status 2.
module fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  fpa_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output fpa_pkg::rsp_t   rsp
);
  import fpa_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  logic          adv;
  logic          f_valid, d_valid;
  side_t         f_side, d_side;
  logic [QW-1:0] f_num, d_quo;
  logic [31:0]   f_den, d_rem, d_den;

  // Advance the pipe unless the output item is held
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req_valid),
    .in_item   (req),
    .out_valid (f_valid),
    .out_side  (f_side),
    .out_num   (f_num),
    .out_den   (f_den)
  );

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_side   (f_side),
    .in_num    (f_num),
    .in_den    (f_den),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quo   (d_quo),
    .out_rem   (d_rem),
    .out_den   (d_den)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_quo    (d_quo),
    .in_rem    (d_rem),
    .in_den    (d_den),
    .out_valid (rsp_valid),
    .out_item  (rsp)
  );

  // A divide-by-zero item carries a zero result and no flag
  a_divzero_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_DIVZERO) |->
      (rsp.result_value == 32'sd0) && !rsp.compare_flag)
    else $error("divide-by-zero item with nonzero payload");

  // A set compare flag comes with a zero result and ok status
  a_flag_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.compare_flag |->
      (rsp.result_value == 32'sd0) && (rsp.status == ST_OK))
    else $error("compare flag with nonzero result or status");

  // A saturated result sits at one of the range bounds
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_SAT) |->
      (rsp.result_value == SMAX) || (rsp.result_value == SMIN))
    else $error("saturated item not at a range bound");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the pipelined fixed-point ALU.
`timescale 1ns / 1ps

module tb_top;
  import fpa_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY   = FRAC_BITS + 35;
  localparam int N_RANDOM  = 1830;
  localparam int MAX_CYC   = 400000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #6 clk = ~clk;

  rsp_t alu_results_due[$];
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_sent = 0;
  int   cycle_cnt = 0;
  bit   hold_rsp = 1'b0;
  bit   drain_done = 1'b0;

  // Saturate a wide value to 32 bits and flag overflow
  function automatic rsp_t saturate(input longint v);
    rsp_t r;
    r = '0;
    if (v > 64'sd2147483647) begin
      r.result_value = SMAX;
      r.status = ST_SAT;
    end else if (v < -64'sd2147483648) begin
      r.result_value = SMIN;
      r.status = ST_SAT;
    end else begin
      r.result_value = v[31:0];
      r.status = ST_OK;
    end
    return r;
  endfunction

  // Compute the result of one operation with exact rounding
  function automatic rsp_t alu_compute(input req_t q);
    rsp_t   r;
    longint a, b, p, m, n, d, qt;
    bit     neg;
    r = '0;
    a = longint'(q.operand_a);
    b = longint'(q.operand_b);
    case (q.kind)
      OP_ADD: r = saturate(a + b);
      OP_SUB: r = saturate(a - b);
      OP_MUL: begin
        p = a * b;
        neg = p < 0;
        m = neg ? -p : p;
        m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r = saturate(neg ? -m : m);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.status = ST_DIVZERO;
        end else begin
          neg = (a < 0) != (b < 0);
          n = (a < 0 ? -a : a) <<< FRAC_BITS;
          d = b < 0 ? -b : b;
          qt = (2 * n + d) / (2 * d);
          r = saturate(neg ? -qt : qt);
        end
      end
      OP_EQ: r.compare_flag = a == b;
      OP_NE: r.compare_flag = a != b;
      OP_LT: r.compare_flag = a < b;
      OP_LE: r.compare_flag = a <= b;
      OP_GT: r.compare_flag = a > b;
      OP_GE: r.compare_flag = a >= b;
      OP_MIN: r.result_value = (a <= b) ? q.operand_a : q.operand_b;
      OP_MAX: r.result_value = (a >= b) ? q.operand_a : q.operand_b;
      OP_INC: r = saturate(a + 1);
      OP_DEC: r = saturate(a - 1);
      OP_TOINT: begin
        neg = a < 0;
        m = (neg ? -a : a) >>> FRAC_BITS;
        r.result_value = neg ? -m : m;
      end
      default: r = saturate(a * (64'sd1 <<< FRAC_BITS));
    endcase
    return r;
  endfunction

  // Directed rows: a known answer is given where it is obvious
  typedef struct {
    op_t         kind;
    logic [31:0] a;
    logic [31:0] b;
    bit          known;
    rsp_t        want;
  } alu_row_t;

  alu_row_t alu_table[] = '{
    '{OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1, '{SMAX, 1'b0, ST_SAT}},
    '{OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 1, '{SMIN, 1'b0, ST_SAT}},
    '{OP_SUB, 32'h8000_0000, 32'h0000_0001, 1, '{SMIN, 1'b0, ST_SAT}},
    '{OP_SUB, 32'h0000_0000, 32'h8000_0000, 1, '{SMAX, 1'b0, ST_SAT}},
    '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 1, '{SMAX, 1'b0, ST_SAT}},
    '{OP_MUL, 32'h0000_0180, 32'hFFFF_FF80, 0, '0},
    '{OP_MUL, 32'h0000_0001, 32'h0000_0080, 0, '0},
    '{OP_DIV, 32'h1234_5678, 32'h0000_0000, 1, '{32'sd0, 1'b0, ST_DIVZERO}},
    '{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1, '{SMAX, 1'b0, ST_SAT}},
    '{OP_DIV, 32'h0000_0100, 32'h0000_0300, 0, '0},
    '{OP_DIV, 32'hFFFF_FF00, 32'h0000_0200, 0, '0},
    '{OP_EQ,  32'h8000_0000, 32'h8000_0000, 1, '{32'sd0, 1'b1, ST_OK}},
    '{OP_NE,  32'h7FFF_FFFF, 32'h8000_0000, 1, '{32'sd0, 1'b1, ST_OK}},
    '{OP_LT,  32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'sd0, 1'b1, ST_OK}},
    '{OP_LE,  32'h7FFF_FFFF, 32'h8000_0000, 1, '{32'sd0, 1'b0, ST_OK}},
    '{OP_GT,  32'h7FFF_FFFF, 32'h8000_0000, 1, '{32'sd0, 1'b1, ST_OK}},
    '{OP_GE,  32'h8000_0000, 32'h7FFF_FFFF, 1, '{32'sd0, 1'b0, ST_OK}},
    '{OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{SMIN, 1'b0, ST_OK}},
    '{OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1, '{SMAX, 1'b0, ST_OK}},
    '{OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, '{SMAX, 1'b0, ST_SAT}},
    '{OP_DEC, 32'h8000_0000, 32'h0000_0000, 1, '{SMIN, 1'b0, ST_SAT}},
    '{OP_TOINT, 32'hFFFF_FE80, 32'h0, 1, '{-32'sd1, 1'b0, ST_OK}},
    '{OP_TOINT, 32'h8000_0000, 32'h0, 1, '{-32'sd8388608, 1'b0, ST_OK}},
    '{OP_FROMINT, 32'h0080_0000, 32'h0, 1, '{SMAX, 1'b0, ST_SAT}},
    '{OP_FROMINT, 32'hFF80_0000, 32'h0, 1, '{SMIN, 1'b0, ST_OK}}
  };

  // Random gap length: mostly short, sometimes long
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operand with bias toward edges and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return 32'(signed'($urandom_range(0, 4096)) - 2048);
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Offer one item and hold it until accepted; valid drops only across a gap
  task automatic send_item(input req_t item);
    int g;
    g = gap_len();
    if (g != 0) begin
      req_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    alu_results_due.push_back(alu_compute(item));
    n_sent++;
    @(negedge clk);
  endtask

  // Sender
  initial begin
    req_t item;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (alu_table[i]) begin
      item.kind = alu_table[i].kind;
      item.operand_a = alu_table[i].a;
      item.operand_b = alu_table[i].b;
      send_item(item);
      if (alu_table[i].known && alu_compute(item) != alu_table[i].want) begin
        n_errors++;
        $display("%0t table row %0d: expected %h got predictor %h", $time, i,
                 alu_table[i].want, alu_compute(item));
      end
      if (alu_table[i].known) begin
        void'(alu_results_due.pop_back());
        alu_results_due.push_back(alu_table[i].want);
      end
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      item.kind = op_t'($urandom_range(0, 15));
      item.operand_a = pick_operand();
      item.operand_b = ($urandom_range(0, 19) == 0) ? 32'h0 : pick_operand();
      if (k == N_RANDOM / 3) hold_rsp = 1'b1;
      if (k == 2 * N_RANDOM / 3) begin
        // pause until every result is back
        req_valid <= 1'b0;
        while (alu_results_due.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_item(item);
    end
    req_valid <= 1'b0;
    while (alu_results_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    drain_done = 1'b1;
  end

  // Receiver stall: random gaps plus one long hold-off
  initial begin
    int g, h;
    @(negedge clk);
    forever begin
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_stall <= 1'b1;
        for (h = 0; h < 3 * LATENCY; h++) @(negedge clk);
        rsp_stall <= 1'b0;
        @(negedge clk);
      end else begin
        g = gap_len();
        rsp_stall <= (g != 0);
        repeat (g == 0 ? $urandom_range(1, 20) : g) @(negedge clk);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (alu_results_due.size() == 0) begin
        n_errors++;
        $display("%0t unexpected result %h", $time, rsp);
      end else begin
        want = alu_results_due.pop_front();
        n_checked++;
        if (rsp.result_value !== want.result_value) begin
          n_errors++;
          $display("%0t result_value expected %h actual %h", $time,
                   want.result_value, rsp.result_value);
        end
        if (rsp.compare_flag !== want.compare_flag) begin
          n_errors++;
          $display("%0t compare_flag expected %b actual %b", $time,
                   want.compare_flag, rsp.compare_flag);
        end
        if (rsp.status !== want.status) begin
          n_errors++;
          $display("%0t status expected %0d actual %0d", $time,
                   want.status, rsp.status);
        end
      end
    end
  end

  // Finish on drain or timeout
  always @(posedge clk) begin
    cycle_cnt++;
    if (drain_done) begin
      if (alu_results_due.size() != 0) n_errors++;
      $display("Sent %0d items over all 16 opcodes, checked %0d results,", n_sent,
               n_checked);
      $display("with saturation, rounding, divide-by-zero and backpressure cases.");
      if (n_errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
    end else if (cycle_cnt > MAX_CYC) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
